/* rtl/core/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg
// Types, constants and the sensor pattern decode shared by the drive block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  localparam int GainW  = 16;
  localparam int DutyW  = 7;
  localparam int ErrW   = 4;
  localparam int SensW  = 5;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;
  localparam int PidW   = 34;

  localparam logic signed [GainW-1:0] IntegLimit = 16'sd32767;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_BASE_DUTY = 3'd3;
  localparam logic [2:0] REG_MAX_DUTY  = 3'd4;

  localparam logic signed [GainW-1:0] GainPReset = 16'sd7680;
  localparam logic [DutyW-1:0] BaseDutyReset = 7'd20;
  localparam logic [DutyW-1:0] MaxDutyReset  = 7'd30;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_NOLINE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_FOLLOW = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_NOLINE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic signed [ErrW-1:0] err;
  } pattern_t;

  typedef struct packed {
    mode_e                  mode;
    logic signed [ErrW-1:0] err;
  } step_t;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [DutyW-1:0]        base_duty;
    logic [DutyW-1:0]        max_duty;
  } cfg_t;

  function automatic pattern_t decode_pattern(logic [SensW-1:0] s);
    pattern_t p;
    p.kind = KIND_NONE;
    p.err  = '0;
    case (s)
      5'd16: begin p.kind = KIND_FOLLOW; p.err = 4'sd4;  end
      5'd24: begin p.kind = KIND_FOLLOW; p.err = 4'sd3;  end
      5'd8:  begin p.kind = KIND_FOLLOW; p.err = 4'sd2;  end
      5'd12: begin p.kind = KIND_FOLLOW; p.err = 4'sd1;  end
      5'd4:  begin p.kind = KIND_FOLLOW; p.err = 4'sd0;  end
      5'd6:  begin p.kind = KIND_FOLLOW; p.err = -4'sd1; end
      5'd2:  begin p.kind = KIND_FOLLOW; p.err = -4'sd2; end
      5'd3:  begin p.kind = KIND_FOLLOW; p.err = -4'sd3; end
      5'd1:  begin p.kind = KIND_FOLLOW; p.err = -4'sd4; end
      5'd31, 5'd15, 5'd30, 5'd14, 5'd7, 5'd28: begin
        p.kind = KIND_STOP;
      end
      5'd0: begin
        p.kind = KIND_NOLINE;
      end
      default: begin
        p.kind = KIND_NONE;
      end
    endcase
    return p;
  endfunction

  // Truncation toward zero then clamp: negative sums always land on 0.
  function automatic logic [DutyW-1:0] clamp_duty(logic signed [PidW-1:0] v,
                                                  logic [DutyW-1:0] maxd);
    logic [PidW-9:0] whole;
    logic [DutyW-1:0] r;
    whole = v[PidW-1:8];
    if (v[PidW-1]) begin
      r = '0;
    end else if (whole > (PidW-8)'(maxd)) begin
      r = maxd;
    end else begin
      r = whole[DutyW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lfpd_sensor_if.sv */
// ----------------------------------------------------------------------------
// lfpd_sensor_if
// Valid/ready channel carrying one line-sensor sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfpd_sensor_if;
  logic       valid;
  logic       ready;
  logic [4:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

`default_nettype wire

/* rtl/core/lfpd_drive_if.sv */
// ----------------------------------------------------------------------------
// lfpd_drive_if
// Valid/ready channel carrying one drive result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfpd_drive_if;
  logic              valid;
  logic              ready;
  logic [1:0]        drive_mode;
  logic signed [3:0] position_error;
  logic [6:0]        left_duty;
  logic [6:0]        right_duty;
  logic              duty_updated;

  modport source (output valid, output drive_mode, output position_error,
                  output left_duty, output right_duty, output duty_updated,
                  input ready);
  modport sink   (input valid, input drive_mode, input position_error,
                  input left_duty, input right_duty, input duty_updated,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/lfpd_front.sv */
// ----------------------------------------------------------------------------
// lfpd_front
// Accepts sensor samples, decodes the pattern and tracks mode and error.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  lfpd_sensor_if.sink          sensor_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output lfpd_pkg::step_t      push_data_o
);

  lfpd_pkg::mode_e                    mode_q, mode_d;
  logic signed [lfpd_pkg::ErrW-1:0]   err_q, err_d;
  lfpd_pkg::pattern_t                 pat;

  assign sensor_i.ready = !full_i;
  assign push_o         = sensor_i.valid && !full_i;
  assign pat            = lfpd_pkg::decode_pattern(sensor_i.sensor_bits);

  always_comb begin
    mode_d = mode_q;
    err_d  = err_q;
    if (pat.kind != lfpd_pkg::KIND_NONE) begin
      mode_d = lfpd_pkg::mode_e'(pat.kind);
      err_d  = pat.err;
    end
  end

  assign push_data_o.mode = mode_d;
  assign push_data_o.err  = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lfpd_pkg::MODE_HOLD;
      err_q  <= '0;
    end else if (push_o) begin
      mode_q <= mode_d;
      err_q  <= err_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lfpd_queue.sv */
// ----------------------------------------------------------------------------
// lfpd_queue
// Small FIFO between the decode front and the PID back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_queue #(
  parameter int Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lfpd_pkg::step_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output lfpd_pkg::step_t      data_o,
  output logic                 empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  lfpd_pkg::step_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lfpd_back.sv */
// ----------------------------------------------------------------------------
// lfpd_back
// Three-stage PID datapath: integral/derivative, products, duty sum and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lfpd_pkg::cfg_t  cfg_i,
  input  wire lfpd_pkg::step_t data_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  lfpd_drive_if.source         drive_o
);

  localparam int GW = lfpd_pkg::GainW;
  localparam int EW = lfpd_pkg::ErrW;
  localparam int DW = lfpd_pkg::DutyW;
  localparam int PW = lfpd_pkg::PidW;

  logic en;

  // running PID state
  logic signed [GW-1:0] integ_q, integ_d;
  logic signed [EW-1:0] prior_q, prior_d;
  logic signed [GW:0]   isum_wide;
  logic signed [GW-1:0] isum_sat;
  logic signed [EW:0]   dterm;

  // stage 1
  logic                 s1_v_q;
  lfpd_pkg::mode_e      s1_mode_q;
  logic signed [EW-1:0] s1_err_q;
  logic signed [GW-1:0] s1_isum_q;
  logic signed [EW:0]   s1_dterm_q;

  // stage 2
  logic                   s2_v_q;
  lfpd_pkg::mode_e        s2_mode_q;
  logic signed [EW-1:0]   s2_err_q;
  logic signed [GW+EW-1:0] prod_p_q;
  logic signed [2*GW-1:0]  prod_i_q;
  logic signed [GW+EW:0]   prod_d_q;

  // output register
  logic                 out_v_q;
  lfpd_pkg::mode_e      out_mode_q;
  logic signed [EW-1:0] out_err_q;
  logic [DW-1:0]        out_left_q, out_left_d;
  logic [DW-1:0]        out_right_q, out_right_d;
  logic                 out_upd_q, out_upd_d;

  logic signed [PW-1:0] pid;
  logic signed [PW-1:0] base_q88;

  assign en    = !out_v_q || drive_o.ready;
  assign pop_o = en && !empty_i;

  always_comb begin
    isum_wide = (GW+1)'(integ_q) + (GW+1)'(data_i.err);
    if (isum_wide > (GW+1)'(lfpd_pkg::IntegLimit)) begin
      isum_sat = lfpd_pkg::IntegLimit;
    end else if (isum_wide < -(GW+1)'(lfpd_pkg::IntegLimit)) begin
      isum_sat = -lfpd_pkg::IntegLimit;
    end else begin
      isum_sat = isum_wide[GW-1:0];
    end
    dterm   = (EW+1)'(data_i.err) - (EW+1)'(prior_q);
    integ_d = integ_q;
    prior_d = prior_q;
    if (pop_o) begin
      case (data_i.mode)
        lfpd_pkg::MODE_FOLLOW: begin
          integ_d = isum_sat;
          prior_d = data_i.err;
        end
        lfpd_pkg::MODE_NOLINE: begin
          prior_d = '0;
        end
        default: begin
          prior_d = prior_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prior_q <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      integ_q <= integ_d;
      prior_q <= prior_d;
      if (en) begin
        s1_v_q <= pop_o;
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_mode_q  <= data_i.mode;
      s1_err_q   <= data_i.err;
      s1_isum_q  <= isum_sat;
      s1_dterm_q <= dterm;
    end
    if (en) begin
      s2_mode_q <= s1_mode_q;
      s2_err_q  <= s1_err_q;
      prod_p_q  <= (GW+EW)'(cfg_i.gain_p) * (GW+EW)'(s1_err_q);
      prod_i_q  <= (2*GW)'(cfg_i.gain_i) * (2*GW)'(s1_isum_q);
      prod_d_q  <= (GW+EW+1)'(cfg_i.gain_d) * (GW+EW+1)'(s1_dterm_q);
    end
  end

  assign pid      = PW'(prod_p_q) + PW'(prod_i_q) + PW'(prod_d_q);
  assign base_q88 = $signed({{(PW-DW-8){1'b0}}, cfg_i.base_duty, 8'h00});

  always_comb begin
    out_left_d  = out_left_q;
    out_right_d = out_right_q;
    out_upd_d   = 1'b0;
    case (s2_mode_q)
      lfpd_pkg::MODE_FOLLOW: begin
        out_left_d  = lfpd_pkg::clamp_duty(base_q88 - pid, cfg_i.max_duty);
        out_right_d = lfpd_pkg::clamp_duty(base_q88 + pid, cfg_i.max_duty);
        out_upd_d   = 1'b1;
      end
      lfpd_pkg::MODE_NOLINE: begin
        out_left_d  = '0;
        out_right_d = '0;
        out_upd_d   = 1'b1;
      end
      default: begin
        out_upd_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q     <= 1'b0;
      out_mode_q  <= lfpd_pkg::MODE_HOLD;
      out_err_q   <= '0;
      out_left_q  <= '0;
      out_right_q <= '0;
      out_upd_q   <= 1'b0;
    end else if (en) begin
      out_v_q <= s2_v_q;
      if (s2_v_q) begin
        out_mode_q  <= s2_mode_q;
        out_err_q   <= s2_err_q;
        out_left_q  <= out_left_d;
        out_right_q <= out_right_d;
        out_upd_q   <= out_upd_d;
      end
    end
  end

  assign drive_o.valid          = out_v_q;
  assign drive_o.drive_mode     = 2'(out_mode_q);
  assign drive_o.position_error = out_err_q;
  assign drive_o.left_duty      = out_left_q;
  assign drive_o.right_duty     = out_right_q;
  assign drive_o.duty_updated   = out_upd_q;

  a_integ_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q != -lfpd_pkg::IntegLimit - 16'sd1)
    else $error("integral left its symmetric range");

  a_noline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && data_i.mode == lfpd_pkg::MODE_NOLINE) |=> (prior_q == '0))
    else $error("previous error not cleared on lost line");

  a_duty_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_upd_q && out_mode_q == lfpd_pkg::MODE_FOLLOW) |->
      (out_left_q <= cfg_i.max_duty && out_right_q <= cfg_i.max_duty))
    else $error("duty above clamp");

endmodule

`default_nettype wire

/* rtl/core/line_follower_pid_drive.sv */
// ----------------------------------------------------------------------------
// line_follower_pid_drive
// Five-sensor line follower decode with a fixed-point PID motor drive.
//
// sensor_i carries one 5-bit sample per transaction (valid/ready); drive_o
// returns exactly one result per sample, in order: mode, position error,
// left and right duty, and whether the duties were rewritten.
// Gains and duty limits sit in an APB register file (gain_p, gain_i,
// gain_d, base_duty, max_duty at 0x0..0x10); write them only while idle.
// The front decodes each sample and updates mode/error in the accept
// cycle, then a queue feeds a three-stage back end (integral and
// derivative, products, sum and clamp) ending in the output register.
// Each sample is registered in the queue, stage 1, stage 2 and the output
// register; one sample per cycle is sustained while drive_o is ready.
// Reset restores the register defaults, clears mode, error, integral and
// duties, and empties the queue and pipeline. When drive_o stalls the back
// end holds, the queue fills and sensor_i.ready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follower_pid_drive #(
  parameter int QueueDepth = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lfpd_pkg::AddrW-1:0]   paddr,
  input  wire logic [lfpd_pkg::DataW-1:0]   pwdata,
  output logic      [lfpd_pkg::DataW-1:0]   prdata,
  output logic                              pready,
  lfpd_sensor_if.sink                       sensor_i,
  lfpd_drive_if.source                      drive_o
);

  lfpd_pkg::cfg_t  cfg_q;
  logic            wr_en;
  logic [2:0]      reg_idx;
  logic            push, full, pop, empty;
  lfpd_pkg::step_t push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= lfpd_pkg::GainPReset;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
      cfg_q.base_duty <= lfpd_pkg::BaseDutyReset;
      cfg_q.max_duty  <= lfpd_pkg::MaxDutyReset;
    end else if (wr_en) begin
      case (reg_idx)
        lfpd_pkg::REG_GAIN_P:    cfg_q.gain_p    <= pwdata[15:0];
        lfpd_pkg::REG_GAIN_I:    cfg_q.gain_i    <= pwdata[15:0];
        lfpd_pkg::REG_GAIN_D:    cfg_q.gain_d    <= pwdata[15:0];
        lfpd_pkg::REG_BASE_DUTY: cfg_q.base_duty <= pwdata[6:0];
        lfpd_pkg::REG_MAX_DUTY:  cfg_q.max_duty  <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfpd_pkg::REG_GAIN_P:    prdata = 32'(cfg_q.gain_p);
      lfpd_pkg::REG_GAIN_I:    prdata = 32'(cfg_q.gain_i);
      lfpd_pkg::REG_GAIN_D:    prdata = 32'(cfg_q.gain_d);
      lfpd_pkg::REG_BASE_DUTY: prdata = 32'(cfg_q.base_duty);
      lfpd_pkg::REG_MAX_DUTY:  prdata = 32'(cfg_q.max_duty);
      default:                 prdata = '0;
    endcase
  end

  lfpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sensor_i    (sensor_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lfpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  lfpd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .data_i  (pop_data),
    .empty_i (empty),
    .pop_o   (pop),
    .drive_o (drive_o)
  );

endmodule

`default_nettype wire

/* dv/tb_line_follower_pid_drive.sv */
// ----------------------------------------------------------------------------
// tb_line_follower_pid_drive
// Self-checking bench for the line follower PID drive. Sensor transactions
// are sent in bursts with random gaps while the result side stalls on its
// own pattern. A predictor tracks mode, error, integral and duties and
// checks every result field. Directed pattern sweeps, register extremes,
// an integral ramp and randomised traffic over several settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_line_follower_pid_drive;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GainW = lfpd_pkg::GainW;
  localparam int DutyW = lfpd_pkg::DutyW;
  localparam int ErrW  = lfpd_pkg::ErrW;
  localparam int SensW = lfpd_pkg::SensW;
  localparam int AddrW = lfpd_pkg::AddrW;
  localparam int DataW = lfpd_pkg::DataW;

  localparam int RegCount   = 5;
  localparam int RegSlots   = 8;
  localparam int IdleCycles = 8;

  typedef struct packed {
    lfpd_pkg::mode_e        mode;
    logic signed [ErrW-1:0] err;
    logic [DutyW-1:0]       left;
    logic [DutyW-1:0]       right;
    logic                   updated;
  } drive_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  lfpd_sensor_if sens ();
  lfpd_drive_if  drv ();

  line_follower_pid_drive u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sensor_i (sens),
    .drive_o  (drv)
  );

  // predictor state and register copy
  lfpd_pkg::cfg_t   drive_cfg;
  lfpd_pkg::mode_e  line_mode;
  int               line_err;
  int               prev_err;
  int               integ_sum;
  logic [DutyW-1:0] left_now;
  logic [DutyW-1:0] right_now;
  drive_t           pending_drive_q[$];

  int mismatch_count;
  int burst_left;
  int gap_max;
  int stall_pct;
  int rx_tick;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("tb_line_follower_pid_drive: FAIL");
    $finish;
  end

  // result side: random stalls plus a periodic stall window
  initial begin
    drv.ready = 1'b0;
    rx_tick   = 0;
    forever begin
      @(negedge clk_i);
      rx_tick++;
      if (stall_pct == 0) begin
        drv.ready <= 1'b1;
      end else if (rx_tick % 48 < 6) begin
        drv.ready <= 1'b0;
      end else begin
        drv.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic lfpd_pkg::pattern_t decode_reading(input logic [SensW-1:0] reading);
    lfpd_pkg::pattern_t pat;
    pat.kind = lfpd_pkg::KIND_FOLLOW;
    pat.err  = '0;
    case (reading)
      5'd0:                                    pat.kind = lfpd_pkg::KIND_NOLINE;
      5'd7, 5'd14, 5'd15, 5'd28, 5'd30, 5'd31: pat.kind = lfpd_pkg::KIND_STOP;
      5'd1:  pat.err = -4'sd4;
      5'd3:  pat.err = -4'sd3;
      5'd2:  pat.err = -4'sd2;
      5'd6:  pat.err = -4'sd1;
      5'd4:  pat.err = 4'sd0;
      5'd12: pat.err = 4'sd1;
      5'd8:  pat.err = 4'sd2;
      5'd24: pat.err = 4'sd3;
      5'd16: pat.err = 4'sd4;
      default:                                 pat.kind = lfpd_pkg::KIND_NONE;
    endcase
    return pat;
  endfunction

  function automatic logic [DutyW-1:0] duty_from_q88(input longint q);
    longint whole;
    whole = q / 256;
    if (whole > longint'(drive_cfg.max_duty)) whole = longint'(drive_cfg.max_duty);
    if (whole < 0) whole = 0;
    return whole[DutyW-1:0];
  endfunction

  function automatic void predict_drive(input logic [SensW-1:0] reading);
    lfpd_pkg::pattern_t pat;
    int                 isum;
    int                 derr;
    longint             pid;
    longint             base_q;
    drive_t             res;
    pat = decode_reading(reading);
    if (pat.kind != lfpd_pkg::KIND_NONE) begin
      line_mode = lfpd_pkg::mode_e'(pat.kind);
      line_err  = pat.err;
    end
    res.updated = 1'b0;
    case (line_mode)
      lfpd_pkg::MODE_NOLINE: begin
        left_now    = '0;
        right_now   = '0;
        prev_err    = 0;
        res.updated = 1'b1;
      end
      lfpd_pkg::MODE_FOLLOW: begin
        isum = integ_sum + line_err;
        if (isum > int'(lfpd_pkg::IntegLimit)) isum = int'(lfpd_pkg::IntegLimit);
        else if (isum < -int'(lfpd_pkg::IntegLimit)) isum = -int'(lfpd_pkg::IntegLimit);
        integ_sum = isum;
        derr      = line_err - prev_err;
        pid = longint'(drive_cfg.gain_p) * line_err
            + longint'(drive_cfg.gain_i) * isum
            + longint'(drive_cfg.gain_d) * derr;
        base_q      = longint'(drive_cfg.base_duty) * 256;
        left_now    = duty_from_q88(base_q - pid);
        right_now   = duty_from_q88(base_q + pid);
        prev_err    = line_err;
        res.updated = 1'b1;
      end
      default: ;
    endcase
    res.mode  = line_mode;
    res.err   = ErrW'(line_err);
    res.left  = left_now;
    res.right = right_now;
    pending_drive_q.push_back(res);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && sens.valid && sens.ready) predict_drive(sens.sensor_bits);
    if (rst_ni && drv.valid && drv.ready) begin
      if (pending_drive_q.size() == 0) begin
        $error("drive result with no transaction pending");
        mismatch_count++;
      end else begin
        want = pending_drive_q.pop_front();
        check_field("drive_mode", int'(want.mode), int'(drv.drive_mode));
        check_field("position_error", int'(want.err), int'(drv.position_error));
        check_field("left_duty", int'(want.left), int'(drv.left_duty));
        check_field("right_duty", int'(want.right), int'(drv.right_duty));
        check_field("duty_updated", int'(want.updated), int'(drv.duty_updated));
      end
    end
  end

  task automatic send_reading(input logic [SensW-1:0] reading);
    @(negedge clk_i);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        sens.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
    end
    burst_left--;
    sens.valid       <= 1'b1;
    sens.sensor_bits <= reading;
    @(posedge clk_i);
    while (!sens.ready) @(posedge clk_i);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    sens.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_idle();
    while (pending_drive_q.size() != 0) @(negedge clk_i);
    repeat (IdleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [GainW-1:0] value);
    logic [DataW-1:0] data;
    data = $urandom;
    if (idx <= lfpd_pkg::REG_GAIN_D) data[GainW-1:0] = value;
    else if (idx <= lfpd_pkg::REG_MAX_DUTY) data[DutyW-1:0] = value[DutyW-1:0];
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lfpd_pkg::REG_GAIN_P:    drive_cfg.gain_p    = data[GainW-1:0];
      lfpd_pkg::REG_GAIN_I:    drive_cfg.gain_i    = data[GainW-1:0];
      lfpd_pkg::REG_GAIN_D:    drive_cfg.gain_d    = data[GainW-1:0];
      lfpd_pkg::REG_BASE_DUTY: drive_cfg.base_duty = data[DutyW-1:0];
      lfpd_pkg::REG_MAX_DUTY:  drive_cfg.max_duty  = data[DutyW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [GainW-1:0] gp, input logic [GainW-1:0] gi,
                           input logic [GainW-1:0] gd, input logic [DutyW-1:0] base,
                           input logic [DutyW-1:0] maxd);
    stop_sending();
    wait_idle();
    write_reg(lfpd_pkg::REG_GAIN_P, gp);
    write_reg(lfpd_pkg::REG_GAIN_I, gi);
    write_reg(lfpd_pkg::REG_GAIN_D, gd);
    write_reg(lfpd_pkg::REG_BASE_DUTY, GainW'(base));
    write_reg(lfpd_pkg::REG_MAX_DUTY, GainW'(maxd));
  endtask

  // every following pattern once, then line lost
  task automatic send_follow_sweep();
    lfpd_pkg::pattern_t pat;
    for (int s = 0; s < 32; s++) begin
      pat = decode_reading(SensW'(s));
      if (pat.kind == lfpd_pkg::KIND_FOLLOW) send_reading(SensW'(s));
    end
    send_reading(5'd0);
  endtask

  function automatic logic [GainW-1:0] rand_gain();
    case ($urandom_range(4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      3:       return GainW'($urandom_range(2047)) - 16'd1024;
      default: return GainW'($urandom);
    endcase
  endfunction

  function automatic logic [DutyW-1:0] rand_duty();
    if ($urandom_range(9) == 0) return DutyW'($urandom_range(101, 127));
    return DutyW'($urandom_range(100));
  endfunction

  // reset settings: hold until a match, every pattern, unmatched in each mode
  task automatic test_directed_patterns();
    logic [SensW-1:0] seq[$];
    gap_max   = 3;
    stall_pct = 20;
    seq = '{5'd5, 5'd9, 5'd4, 5'd16, 5'd24, 5'd8, 5'd12, 5'd6, 5'd2, 5'd3,
            5'd1, 5'd21, 5'd31, 5'd15, 5'd30, 5'd14, 5'd7, 5'd28, 5'd10,
            5'd0, 5'd19, 5'd4, 5'd17};
    foreach (seq[i]) send_reading(seq[i]);
  endtask

  task automatic test_register_extremes();
    gap_max   = 2;
    stall_pct = 30;
    write_all(16'h7FFF, 16'h8000, 16'h7FFF, 7'd100, 7'd100);
    send_follow_sweep();
    write_all(16'h8000, 16'h7FFF, 16'h8000, 7'd0, 7'd0);
    send_follow_sweep();
    // duties above 100 are taken as given
    write_all(16'h0000, 16'h0000, 16'h0000, 7'd127, 7'd127);
    send_follow_sweep();
    write_all(16'h0100, 16'h0040, 16'hFF00, 7'd64, 7'd101);
    // unused addresses must leave the registers alone
    for (int k = 0; k < 4; k++) begin
      write_reg(3'($urandom_range(RegCount, RegSlots - 1)), GainW'($urandom));
    end
    send_follow_sweep();
  endtask

  // integral alone drives the duties, ramped up, through zero and back
  task automatic test_integral_ramp();
    gap_max   = 0;
    stall_pct = 0;
    write_all(16'h0000, 16'h0001, 16'h0000, 7'd0, 7'd127);
    repeat (120) send_reading(5'd16);
    repeat (160) send_reading(5'd1);
    repeat (20) send_reading(5'd16);
  endtask

  task automatic test_random_traffic();
    logic [SensW-1:0]   reading;
    lfpd_pkg::pattern_t pat;
    lfpd_pkg::kind_e    want_kind;
    int                 r;
    int                 sent;
    for (int phase = 0; phase < 6; phase++) begin
      stop_sending();
      wait_idle();
      if (phase == 0 || $urandom_range(1)) write_reg(lfpd_pkg::REG_GAIN_P, rand_gain());
      if (phase == 0 || $urandom_range(1)) write_reg(lfpd_pkg::REG_GAIN_I, rand_gain());
      if (phase == 0 || $urandom_range(1)) write_reg(lfpd_pkg::REG_GAIN_D, rand_gain());
      if (phase == 0 || $urandom_range(1)) begin
        write_reg(lfpd_pkg::REG_BASE_DUTY, GainW'(rand_duty()));
      end
      if (phase == 0 || $urandom_range(1)) begin
        write_reg(lfpd_pkg::REG_MAX_DUTY, GainW'(rand_duty()));
      end
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        2:       stall_pct = 30;
        default: stall_pct = 60;
      endcase
      sent = 0;
      while (sent < 240) begin
        r = $urandom_range(99);
        // KIND_NONE here means any reading at all
        want_kind = (r < 55) ? lfpd_pkg::KIND_FOLLOW :
                    (r < 70) ? lfpd_pkg::KIND_STOP :
                    (r < 80) ? lfpd_pkg::KIND_NOLINE : lfpd_pkg::KIND_NONE;
        repeat ($urandom_range(1, 10)) begin
          reading = SensW'($urandom_range(31));
          pat     = decode_reading(reading);
          while (want_kind != lfpd_pkg::KIND_NONE && pat.kind != want_kind) begin
            reading = SensW'($urandom_range(31));
            pat     = decode_reading(reading);
          end
          send_reading(reading);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    sens.valid       = 1'b0;
    sens.sensor_bits = '0;
    mismatch_count   = 0;
    burst_left       = 0;
    gap_max          = 0;
    stall_pct        = 0;
    drive_cfg.gain_p    = lfpd_pkg::GainPReset;
    drive_cfg.gain_i    = '0;
    drive_cfg.gain_d    = '0;
    drive_cfg.base_duty = lfpd_pkg::BaseDutyReset;
    drive_cfg.max_duty  = lfpd_pkg::MaxDutyReset;
    line_mode = lfpd_pkg::MODE_HOLD;
    line_err  = 0;
    prev_err  = 0;
    integ_sum = 0;
    left_now  = '0;
    right_now = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_patterns();
    test_register_extremes();
    test_integral_ramp();
    test_random_traffic();

    stop_sending();
    wait_idle();
    if (mismatch_count == 0 && pending_drive_q.size() == 0) begin
      $display("tb_line_follower_pid_drive: PASS");
    end else begin
      $display("tb_line_follower_pid_drive: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/lfpd_pkg.sv
rtl/core/lfpd_sensor_if.sv
rtl/core/lfpd_drive_if.sv
rtl/core/lfpd_front.sv
rtl/core/lfpd_queue.sv
rtl/core/lfpd_back.sv
rtl/core/line_follower_pid_drive.sv
dv/tb_line_follower_pid_drive.sv
